### rtl/assert_macros.svh
// assertion macros for the rtl files that check themselves
// depends on nothing; take it in by include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a rising clock, muted while reset is held
`define DMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check with no reset condition
`define DMF_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dmf_pkg.sv
// shared types and constants of the dinic max-flow unit
// used by the controller, the datapath and the top level
package dmf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int ARC_SLOTS    = 2 * MAX_EDGES;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int EDGE_W       = $clog2(MAX_EDGES);
    localparam int CNT_W        = EDGE_W + 1;
    localparam int ARC_W        = $clog2(ARC_SLOTS);
    localparam int PTR_W        = ARC_W + 1;
    localparam int CAP_W        = 16;
    localparam int FLOW_W       = 24;
    localparam int LVL_W        = VTX_W + 1;
    localparam int DEPTH_W      = VTX_W + 1;
    localparam int VC_W         = 7;
    localparam int STAT_W       = 2;
    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = 32;

    localparam logic [PTR_W-1:0] END_MARK = PTR_W'(ARC_SLOTS);
    localparam logic [VC_W-1:0]  VC_MIN   = VC_W'(2);
    localparam logic [VC_W-1:0]  VC_MAX   = VC_W'(MAX_VERTICES);

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_VTX = 2'd2;

    typedef enum logic [4:0] {
        OP_IDLE, OP_CHK, OP_L1, OP_L2, OP_L3,
        OP_B0, OP_B1, OP_B2, OP_B3, OP_B4, OP_B5,
        OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6,
        OP_A0, OP_A1, OP_A2, OP_U0, OP_U1, OP_U2, OP_U3,
        OP_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic in_xfer;
        logic edge_ok;
        logic last;
        logic q_empty;
        logic sink_reached;
        logic a_end;
        logic depth_zero;
        logic v_sink;
        logic take;
        logic i_last;
        logic out_busy;
    } dp_stat_t;

endpackage

### rtl/dmf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/dmf_ctrl.sv
// sequencer of the max-flow unit: edge load, level pass, pushes, result
// depends on dmf_pkg
module dmf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  dmf_pkg::dp_stat_t stat,
    output dmf_pkg::dp_cmd_t  cmd
);
    import dmf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHK, ST_L1, ST_L2, ST_L3,
        ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
        ST_A0, ST_A1, ST_A2, ST_U0, ST_U1, ST_U2, ST_U3,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (stat.in_xfer) state_next = ST_CHK;
            ST_CHK: begin
                if (stat.edge_ok) state_next = ST_L1;
                else state_next = stat.last ? ST_B0 : ST_IDLE;
            end
            ST_L1: state_next = ST_L2;
            ST_L2: state_next = ST_L3;
            ST_L3: state_next = stat.last ? ST_B0 : ST_IDLE;
            ST_B0: state_next = ST_B1;
            ST_B1: begin
                if (stat.q_empty) state_next = stat.sink_reached ? ST_P0 : ST_FIN;
                else state_next = ST_B2;
            end
            ST_B2: state_next = ST_B3;
            ST_B3: state_next = ST_B4;
            ST_B4: state_next = stat.a_end ? ST_B1 : ST_B5;
            ST_B5: state_next = ST_B4;
            ST_P0: state_next = stat.v_sink ? ST_A0 : ST_P1;
            ST_P1: state_next = ST_P2;
            ST_P2: begin
                // dead end at the source closes the phase
                if (stat.a_end) state_next = stat.depth_zero ? ST_B0 : ST_P3;
                else state_next = ST_P4;
            end
            ST_P3: state_next = ST_P6;
            ST_P6: state_next = ST_P0;
            ST_P4: state_next = ST_P5;
            ST_P5: state_next = stat.take ? ST_P0 : ST_P2;
            ST_A0: state_next = ST_A1;
            ST_A1: state_next = ST_A2;
            ST_A2: state_next = stat.i_last ? ST_U0 : ST_A1;
            ST_U0: state_next = ST_U1;
            ST_U1: state_next = ST_U2;
            ST_U2: state_next = ST_U3;
            ST_U3: state_next = stat.i_last ? ST_P0 : ST_U1;
            ST_FIN: if (!stat.out_busy) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE: cmd.op = OP_IDLE;
            ST_CHK:  cmd.op = OP_CHK;
            ST_L1:   cmd.op = OP_L1;
            ST_L2:   cmd.op = OP_L2;
            ST_L3:   cmd.op = OP_L3;
            ST_B0:   cmd.op = OP_B0;
            ST_B1:   cmd.op = OP_B1;
            ST_B2:   cmd.op = OP_B2;
            ST_B3:   cmd.op = OP_B3;
            ST_B4:   cmd.op = OP_B4;
            ST_B5:   cmd.op = OP_B5;
            ST_P0:   cmd.op = OP_P0;
            ST_P1:   cmd.op = OP_P1;
            ST_P2:   cmd.op = OP_P2;
            ST_P3:   cmd.op = OP_P3;
            ST_P4:   cmd.op = OP_P4;
            ST_P5:   cmd.op = OP_P5;
            ST_P6:   cmd.op = OP_P6;
            ST_A0:   cmd.op = OP_A0;
            ST_A1:   cmd.op = OP_A1;
            ST_A2:   cmd.op = OP_A2;
            ST_U0:   cmd.op = OP_U0;
            ST_U1:   cmd.op = OP_U1;
            ST_U2:   cmd.op = OP_U2;
            ST_U3:   cmd.op = OP_U3;
            ST_FIN:  cmd.op = OP_FIN;
            default: cmd.op = OP_IDLE;
        endcase
    end

endmodule

### rtl/dmf_dp.sv
// datapath of the max-flow unit: arc and vertex memories, counters, result register
// depends on dmf_pkg and dmf_ram
module dmf_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dmf_pkg::dp_cmd_t                    cmd,
    output dmf_pkg::dp_stat_t                   stat,
    input  logic                                cfg_we,
    input  logic [dmf_pkg::VC_W-1:0]            cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dmf_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dmf_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import dmf_pkg::*;

    logic [VC_W-1:0]         vc_reg;
    logic [VTX_W-1:0]        s_reg, d_reg, v_reg, t_reg;
    logic [CAP_W-1:0]        c_reg, res_reg, amt_reg;
    logic                    last_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [1:0]              err_reg;
    logic [MAX_VERTICES-1:0] head_vld_reg, reached_reg, cur_vld_reg;
    logic [LVL_W-1:0]        lvl_reg;
    logic [PTR_W-1:0]        a_reg, nxt_reg;
    logic [DEPTH_W-1:0]      qh_reg, qt_reg, depth_reg, i_reg;
    logic [ARC_W-1:0]        pa_reg;
    logic [FLOW_W-1:0]       total_reg;
    logic                    out_vld_reg;
    logic [OUT_DATA_W-1:0]   out_reg;
    logic [VTX_W-1:0]        lh_raddr_q;

    // memory ports
    logic             ahd_we, res_we, nxt_we, lh_we, lvl_we, cur_we, q_we, stk_we;
    logic [ARC_W-1:0] ahd_waddr, ahd_raddr, res_waddr, res_raddr, nxt_waddr, nxt_raddr;
    logic [VTX_W-1:0] ahd_wdata, ahd_rdata;
    logic [CAP_W-1:0] res_wdata, res_rdata;
    logic [PTR_W-1:0] nxt_wdata, nxt_rdata, lh_wdata, lh_rdata, cur_wdata, cur_rdata;
    logic [VTX_W-1:0] lh_waddr, lh_raddr, lvl_waddr, lvl_raddr, cur_waddr, cur_raddr;
    logic [VTX_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata, stk_waddr, stk_raddr;
    logic [LVL_W-1:0] lvl_wdata, lvl_rdata;
    logic [ARC_W-1:0] stk_wdata, stk_rdata;

    logic [ARC_W-1:0] fa, ra;
    logic [VTX_W-1:0] sink;
    logic [PTR_W-1:0] head_val, cur_val;
    logic             in_xfer, out_busy, bad_vtx;
    logic [STAT_W-1:0] status;

    assign fa       = {cnt_reg[EDGE_W-1:0], 1'b0};
    assign ra       = {cnt_reg[EDGE_W-1:0], 1'b1};
    assign sink     = VTX_W'(vc_reg - VC_W'(1));
    assign head_val = head_vld_reg[lh_raddr_q] ? lh_rdata : END_MARK;
    assign cur_val  = cur_vld_reg[v_reg] ? cur_rdata : head_val;
    assign s_tready = (cmd.op == OP_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_busy = out_vld_reg && !m_tready;
    assign bad_vtx  = ({1'b0, s_reg} >= vc_reg) || ({1'b0, d_reg} >= vc_reg);
    assign status   = err_reg[1] ? STATUS_BAD_VTX : (err_reg[0] ? STATUS_FULL : STATUS_OK);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    assign stat.in_xfer      = in_xfer;
    assign stat.edge_ok      = !bad_vtx && !cnt_reg[CNT_W-1];
    assign stat.last         = last_reg;
    assign stat.q_empty      = (qh_reg == qt_reg);
    assign stat.sink_reached = reached_reg[sink];
    assign stat.a_end        = (a_reg == END_MARK);
    assign stat.depth_zero   = (depth_reg == '0);
    assign stat.v_sink       = (v_reg == sink);
    assign stat.take         = reached_reg[t_reg] && (lvl_rdata == lvl_reg + LVL_W'(1))
                               && (res_reg != '0);
    assign stat.i_last       = (i_reg + DEPTH_W'(1) == depth_reg);
    assign stat.out_busy     = out_busy;

    always_comb begin
        ahd_we = 1'b0; ahd_waddr = '0; ahd_wdata = '0; ahd_raddr = a_reg[ARC_W-1:0];
        res_we = 1'b0; res_waddr = '0; res_wdata = '0; res_raddr = a_reg[ARC_W-1:0];
        nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = '0; nxt_raddr = a_reg[ARC_W-1:0];
        lh_we  = 1'b0; lh_waddr  = '0; lh_wdata  = '0; lh_raddr  = v_reg;
        lvl_we = 1'b0; lvl_waddr = '0; lvl_wdata = '0; lvl_raddr = v_reg;
        cur_we = 1'b0; cur_waddr = '0; cur_wdata = '0; cur_raddr = v_reg;
        q_we   = 1'b0; q_waddr   = '0; q_wdata   = '0; q_raddr   = qh_reg[VTX_W-1:0];
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0;
        stk_raddr = VTX_W'(i_reg + DEPTH_W'(1));
        case (cmd.op)
            OP_CHK: begin
                ahd_waddr = fa; ahd_wdata = d_reg;
                res_waddr = fa; res_wdata = c_reg;
                ahd_we    = stat.edge_ok;
                res_we    = stat.edge_ok;
                lh_raddr  = s_reg;
            end
            OP_L1: begin
                nxt_we = 1'b1; nxt_waddr = fa; nxt_wdata = head_val;
                lh_we  = 1'b1; lh_waddr  = s_reg; lh_wdata = {1'b0, fa};
                ahd_we = 1'b1; ahd_waddr = ra; ahd_wdata = s_reg;
                res_we = 1'b1; res_waddr = ra; res_wdata = '0;
            end
            OP_L2: lh_raddr = d_reg;
            OP_L3: begin
                nxt_we = 1'b1; nxt_waddr = ra; nxt_wdata = head_val;
                lh_we  = 1'b1; lh_waddr  = d_reg; lh_wdata = {1'b0, ra};
            end
            OP_B0: begin
                lvl_we = 1'b1; lvl_waddr = '0; lvl_wdata = '0;
                q_we   = 1'b1; q_waddr   = '0; q_wdata   = '0;
            end
            OP_B2: begin
                lh_raddr  = q_rdata;
                lvl_raddr = q_rdata;
            end
            OP_B5: begin
                if (res_rdata != '0 && !reached_reg[ahd_rdata]) begin
                    lvl_we = 1'b1; lvl_waddr = ahd_rdata; lvl_wdata = lvl_reg + LVL_W'(1);
                    q_we   = 1'b1; q_waddr   = qt_reg[VTX_W-1:0]; q_wdata = ahd_rdata;
                end
            end
            OP_P2: stk_raddr = VTX_W'(depth_reg - DEPTH_W'(1));
            OP_P3: begin
                ahd_raddr = stk_rdata ^ ARC_W'(1);
                nxt_raddr = stk_rdata;
            end
            OP_P6: begin
                cur_we = 1'b1; cur_waddr = ahd_rdata; cur_wdata = nxt_rdata;
            end
            OP_P4: lvl_raddr = ahd_rdata;
            OP_P5: begin
                if (stat.take) begin
                    stk_we = 1'b1; stk_waddr = depth_reg[VTX_W-1:0];
                    stk_wdata = a_reg[ARC_W-1:0];
                end else begin
                    cur_we = 1'b1; cur_waddr = v_reg; cur_wdata = nxt_reg;
                end
            end
            OP_A0, OP_U0: stk_raddr = '0;
            OP_A1, OP_U1: res_raddr = stk_rdata;
            OP_U2: begin
                res_we = 1'b1; res_waddr = pa_reg; res_wdata = res_rdata - amt_reg;
                res_raddr = pa_reg ^ ARC_W'(1);
            end
            OP_U3: begin
                res_we = 1'b1; res_waddr = pa_reg ^ ARC_W'(1);
                res_wdata = res_rdata + amt_reg;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg       <= VC_MAX;
            cnt_reg      <= '0;
            err_reg      <= '0;
            head_vld_reg <= '0;
            total_reg    <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_wdata < VC_MIN) vc_reg <= VC_MIN;
                else if (cfg_wdata > VC_MAX) vc_reg <= VC_MAX;
                else vc_reg <= cfg_wdata;
            end
            // the finish step reloads the output register itself
            if (out_vld_reg && m_tready && cmd.op != OP_FIN) out_vld_reg <= 1'b0;
            case (cmd.op)
                OP_CHK: begin
                    if (bad_vtx) err_reg[1] <= 1'b1;
                    else if (cnt_reg[CNT_W-1]) err_reg[0] <= 1'b1;
                end
                OP_L1: head_vld_reg[s_reg] <= 1'b1;
                OP_L3: begin
                    head_vld_reg[d_reg] <= 1'b1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                OP_U3: if (stat.i_last) total_reg <= total_reg + FLOW_W'(amt_reg);
                OP_FIN: begin
                    if (!out_busy) begin
                        out_vld_reg  <= 1'b1;
                        cnt_reg      <= '0;
                        err_reg      <= '0;
                        head_vld_reg <= '0;
                        total_reg    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        lh_raddr_q <= lh_raddr;
        if (in_xfer) begin
            s_reg    <= s_tdata[VTX_W-1:0];
            d_reg    <= s_tdata[2*VTX_W-1:VTX_W];
            c_reg    <= s_tdata[2*VTX_W+CAP_W-1:2*VTX_W];
            last_reg <= s_tlast;
        end
        case (cmd.op)
            OP_B0: begin
                reached_reg    <= MAX_VERTICES'(1);
                cur_vld_reg    <= '0;
                qh_reg         <= '0;
                qt_reg         <= DEPTH_W'(1);
            end
            OP_B1: begin
                if (qh_reg == qt_reg) begin
                    v_reg     <= '0;
                    depth_reg <= '0;
                end else begin
                    qh_reg <= qh_reg + DEPTH_W'(1);
                end
            end
            OP_B2: v_reg <= q_rdata;
            OP_B3: begin
                lvl_reg <= lvl_rdata;
                a_reg   <= head_val;
            end
            OP_B5: begin
                if (res_rdata != '0 && !reached_reg[ahd_rdata]) begin
                    reached_reg[ahd_rdata] <= 1'b1;
                    qt_reg <= qt_reg + DEPTH_W'(1);
                end
                a_reg <= nxt_rdata;
            end
            OP_P1: begin
                a_reg   <= cur_val;
                lvl_reg <= lvl_rdata;
            end
            OP_P2: if (a_reg == END_MARK && depth_reg != '0) depth_reg <= depth_reg - DEPTH_W'(1);
            OP_P6: begin
                v_reg <= ahd_rdata;
                cur_vld_reg[ahd_rdata] <= 1'b1;
            end
            OP_P4: begin
                t_reg   <= ahd_rdata;
                res_reg <= res_rdata;
                nxt_reg <= nxt_rdata;
            end
            OP_P5: begin
                if (stat.take) begin
                    depth_reg <= depth_reg + DEPTH_W'(1);
                    v_reg     <= t_reg;
                end else begin
                    cur_vld_reg[v_reg] <= 1'b1;
                    a_reg <= nxt_reg;
                end
            end
            OP_A0: begin
                i_reg   <= '0;
                amt_reg <= '1;
            end
            OP_A2: begin
                if (res_rdata < amt_reg) amt_reg <= res_rdata;
                i_reg <= i_reg + DEPTH_W'(1);
            end
            OP_U0: i_reg <= '0;
            OP_U1: pa_reg <= stk_rdata;
            OP_U3: begin
                i_reg <= i_reg + DEPTH_W'(1);
                if (stat.i_last) begin
                    v_reg     <= '0;
                    depth_reg <= '0;
                end
            end
            OP_FIN: begin
                if (!out_busy) begin
                    out_reg <= OUT_DATA_W'({status, total_reg});
                end
            end
            default: ;
        endcase
    end

    dmf_ram #(.WIDTH(VTX_W), .DEPTH(ARC_SLOTS)) u_arc_head (
        .aclk(aclk), .we(ahd_we), .waddr(ahd_waddr), .wdata(ahd_wdata),
        .raddr(ahd_raddr), .rdata(ahd_rdata));
    dmf_ram #(.WIDTH(CAP_W), .DEPTH(ARC_SLOTS)) u_arc_res (
        .aclk(aclk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .raddr(res_raddr), .rdata(res_rdata));
    dmf_ram #(.WIDTH(PTR_W), .DEPTH(ARC_SLOTS)) u_arc_next (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(nxt_raddr), .rdata(nxt_rdata));
    dmf_ram #(.WIDTH(PTR_W), .DEPTH(MAX_VERTICES)) u_list_head (
        .aclk(aclk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(lh_raddr), .rdata(lh_rdata));
    dmf_ram #(.WIDTH(LVL_W), .DEPTH(MAX_VERTICES)) u_level (
        .aclk(aclk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
        .raddr(lvl_raddr), .rdata(lvl_rdata));
    dmf_ram #(.WIDTH(PTR_W), .DEPTH(MAX_VERTICES)) u_cur_arc (
        .aclk(aclk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
        .raddr(cur_raddr), .rdata(cur_rdata));
    dmf_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_bfs_queue (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata));
    dmf_ram #(.WIDTH(ARC_W), .DEPTH(MAX_VERTICES)) u_path_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata));

endmodule

### rtl/dinic_max_flow_unit.sv
// Max-flow engine (Dinic). Edges stream in one per transfer; a kept edge passes
// accept, range check and two list-head updates through the single-read-port
// list-head memory, a dropped edge only accept and range check. After the edge
// flagged tlast the unit runs level passes and blocking-flow pushes, all through
// single-read-port arc memories, so the run time depends on the graph. No new
// edge is taken during the run; the result (max flow and drop status) waits in
// an output register.
// depends on dmf_pkg, dmf_ctrl, dmf_dp, assert_macros.svh
`include "assert_macros.svh"

module dinic_max_flow_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [dmf_pkg::VC_W-1:0]       cfg_wdata,   // vertex_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dmf_pkg::IN_DATA_W-1:0]  s_tdata,     // src_vertex, dst_vertex, capacity
    input  logic                           s_tlast,     // last_edge
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dmf_pkg::OUT_DATA_W-1:0] m_tdata      // max_flow, status
);
    import dmf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dmf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .stat(stat), .cmd(cmd));

    dmf_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

    // in the cycle after an accepted edge no new edge is taken
    `DMF_ASSERT(a_accept_then_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "back to back")
    // a result only shows up from the finish step
    `DMF_ASSERT(a_result_from_fin, aclk, aresetn, $rose(m_tvalid) |-> $past(cmd.op == OP_FIN), "no fin")
    // the push search never leaves the sink pending with an empty path
    `DMF_ASSERT(a_sink_has_path, aclk, aresetn, cmd.op == OP_A0 |-> !stat.depth_zero, "empty path")

endmodule
